// ----- src/ff_header_frame_parser_unit_defines.svh -----
// assertion macros used by the checker file
`ifndef FF_HEADER_FRAME_PARSER_UNIT_DEFINES_SVH
`define FF_HEADER_FRAME_PARSER_UNIT_DEFINES_SVH

// same-cycle implication under the active-low reset
`define FFHP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under the active-low reset
`define FFHP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/ffhp_pkg.sv -----
// ----------------------------------------------------------------------------
// ffhp_pkg
// Shared constants and control structs of the header frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ffhp_pkg;

	// field widths fixed by the result format
	localparam int BYTE_W      = 8;
	localparam int FRAME_LEN_W = 5;
	localparam int PARAM_IDX_W = 4;

	// header byte value
	localparam logic [BYTE_W-1:0] HDR_BYTE = 8'hFF;

	// commands from controller to datapath
	typedef struct packed {
		logic cap_first;
		logic cap_type;
		logic cap_len;
		logic drop_len;
		logic wr_param;
		logic clr_cnt;
		logic inc_cnt;
	} ffhp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic hdr_ok;
		logic len_ok;
		logic len_zero;
		logic cnt_last;
		logic csum_ok;
	} ffhp_sts_t;

endpackage

`default_nettype wire

// ----- src/ffhp_if.sv -----
// ----------------------------------------------------------------------------
// ffhp_if
// Valid/ready channels: received byte words in, parsed result words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffhp_rx_if;
	import ffhp_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface ffhp_res_if;
	import ffhp_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [BYTE_W-1:0]      frame_type;
	logic [FRAME_LEN_W-1:0] frame_length;
	logic [PARAM_IDX_W-1:0] param_index;
	logic [BYTE_W-1:0]      param_value;
	logic                   param_present;
	logic                   last_item;
	modport source (output valid, output frame_type, output frame_length,
		output param_index, output param_value, output param_present,
		output last_item, input ready);
	modport sink (input valid, input frame_type, input frame_length,
		input param_index, input param_value, input param_present,
		input last_item, output ready);
endinterface

`default_nettype wire

// ----- src/ffhp_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffhp_ctrl
// Frame parse and result release state machine; drives datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module ffhp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rx_valid,
	output logic                   rx_ready,
	output logic                   res_valid,
	input  wire logic              res_ready,
	input  wire ffhp_pkg::ffhp_sts_t sts,
	output ffhp_pkg::ffhp_cmd_t    cmd
);
	import ffhp_pkg::*;

	typedef enum logic [2:0] {
		ST_HDR1,
		ST_HDR2,
		ST_TYPE,
		ST_LEN,
		ST_PARAM,
		ST_CSUM,
		ST_LOAD,
		ST_SHOW
	} state_t;

	state_t state_q;
	logic   rx_acc;
	logic   res_acc;

	// handshakes
	assign rx_ready  = (state_q != ST_LOAD) && (state_q != ST_SHOW);
	assign res_valid = (state_q == ST_SHOW);
	assign rx_acc    = rx_valid && rx_ready;
	assign res_acc   = res_valid && res_ready;

	// datapath commands
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_HDR1:  cmd.cap_first = rx_acc;
			ST_HDR2:  cmd = '0;
			ST_TYPE:  cmd.cap_type = rx_acc;
			ST_LEN: begin
				cmd.cap_len  = rx_acc && sts.len_ok;
				cmd.clr_cnt  = rx_acc && sts.len_ok;
				cmd.drop_len = rx_acc && !sts.len_ok;
			end
			ST_PARAM: cmd.wr_param = rx_acc;
			ST_CSUM:  cmd.clr_cnt = rx_acc && sts.csum_ok;
			ST_LOAD:  cmd = '0;
			ST_SHOW:  cmd.inc_cnt = res_acc && !sts.cnt_last;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HDR1;
		end else begin
			unique case (state_q)
				ST_HDR1: begin
					if (rx_acc) state_q <= ST_HDR2;
				end
				ST_HDR2: begin
					if (rx_acc) state_q <= sts.hdr_ok ? ST_TYPE : ST_HDR1;
				end
				ST_TYPE: begin
					if (rx_acc) state_q <= ST_LEN;
				end
				ST_LEN: begin
					if (rx_acc) begin
						if (!sts.len_ok)      state_q <= ST_HDR1;
						else if (sts.len_zero) state_q <= ST_CSUM;
						else                  state_q <= ST_PARAM;
					end
				end
				ST_PARAM: begin
					if (rx_acc && sts.cnt_last) state_q <= ST_CSUM;
				end
				ST_CSUM: begin
					if (rx_acc) state_q <= sts.csum_ok ? ST_LOAD : ST_HDR1;
				end
				ST_LOAD: state_q <= ST_SHOW;
				ST_SHOW: begin
					if (res_acc) state_q <= sts.cnt_last ? ST_HDR1 : ST_LOAD;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- src/ffhp_dp.sv -----
// ----------------------------------------------------------------------------
// ffhp_dp
// Header, length and checksum registers, parameter memory and result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module ffhp_dp #(
	parameter int MAX_PARAMS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [ffhp_pkg::BYTE_W-1:0]     rx_byte,
	input  wire ffhp_pkg::ffhp_cmd_t             cmd,
	output ffhp_pkg::ffhp_sts_t                  sts,
	output logic [ffhp_pkg::BYTE_W-1:0]          frame_type,
	output logic [ffhp_pkg::FRAME_LEN_W-1:0]     frame_length,
	output logic [ffhp_pkg::PARAM_IDX_W-1:0]     param_index,
	output logic [ffhp_pkg::BYTE_W-1:0]          param_value,
	output logic                                 param_present,
	output logic                                 last_item
);
	import ffhp_pkg::*;

	localparam int AW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
	localparam int LW = $clog2(MAX_PARAMS + 1);

	logic [BYTE_W-1:0] first_q;
	logic [BYTE_W-1:0] type_q;
	logic [LW-1:0]     len_q;
	logic [BYTE_W-1:0] sum_q;
	logic [AW-1:0]     cnt_q;
	logic [BYTE_W-1:0] rd_q;
	logic [BYTE_W-1:0] mem [MAX_PARAMS];
	logic              held_zero;

	// status toward the controller
	assign held_zero    = (len_q == '0);
	assign sts.hdr_ok   = (first_q == HDR_BYTE) && (rx_byte == HDR_BYTE);
	assign sts.len_ok   = (rx_byte <= BYTE_W'(MAX_PARAMS));
	assign sts.len_zero = (rx_byte == '0);
	assign sts.cnt_last = held_zero || ((LW'(cnt_q) + LW'(1)) == len_q);
	assign sts.csum_ok  = (~sum_q == rx_byte);

	// frame registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			type_q  <= '0;
			len_q   <= '0;
			sum_q   <= '0;
			cnt_q   <= '0;
		end else begin
			if (cmd.cap_first) first_q <= rx_byte;
			if (cmd.cap_type) begin
				type_q <= rx_byte;
				sum_q  <= rx_byte;
			end
			if (cmd.cap_len) begin
				len_q <= LW'(rx_byte);
				sum_q <= sum_q + rx_byte;
			end
			if (cmd.drop_len) len_q <= '0;
			if (cmd.wr_param) begin
				sum_q <= sum_q + rx_byte;
				cnt_q <= cnt_q + AW'(1);
			end
			if (cmd.clr_cnt) cnt_q <= '0;
			if (cmd.inc_cnt) cnt_q <= cnt_q + AW'(1);
		end
	end

	// parameter memory, registered read at the counter
	always_ff @(posedge clk) begin
		if (cmd.wr_param) mem[cnt_q] <= rx_byte;
		rd_q <= mem[cnt_q];
	end

	// result word fields
	assign frame_type    = type_q;
	assign frame_length  = FRAME_LEN_W'(len_q);
	assign param_index   = PARAM_IDX_W'(cnt_q);
	assign param_present = !held_zero;
	assign param_value   = held_zero ? '0 : rd_q;
	assign last_item     = sts.cnt_last;

endmodule

`default_nettype wire

// ----- src/ff_header_frame_parser_unit.sv -----
// Results follow a taken checksum word through the ST_LOAD and ST_SHOW states.
// Throughput: one received word per cycle while parsing; after a good checksum,
// each result is loaded (parameter memory read register), then shown until taken.
// Input is held off until the last result is taken (one empty one if no params).
// Reset: asynchronous, active low; parser returns to the first header byte,
// parameter memory is not cleared.
// ----------------------------------------------------------------------------
// ff_header_frame_parser_unit
// Parses 0xFF 0xFF type length params checksum frames into result words.
// ----------------------------------------------------------------------------
`default_nettype none

module ff_header_frame_parser_unit #(
	parameter int MAX_PARAMS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ffhp_rx_if.sink   rx_ch,
	ffhp_res_if.source res_ch
);
	import ffhp_pkg::*;

	ffhp_cmd_t cmd;
	ffhp_sts_t sts;

	// controller
	ffhp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_ch.valid),
		.rx_ready  (rx_ch.ready),
		.res_valid (res_ch.valid),
		.res_ready (res_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath
	ffhp_dp #(
		.MAX_PARAMS (MAX_PARAMS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx_byte       (rx_ch.rx_byte),
		.cmd           (cmd),
		.sts           (sts),
		.frame_type    (res_ch.frame_type),
		.frame_length  (res_ch.frame_length),
		.param_index   (res_ch.param_index),
		.param_value   (res_ch.param_value),
		.param_present (res_ch.param_present),
		.last_item     (res_ch.last_item)
	);

endmodule

`default_nettype wire

// ----- src/ffhp_checker.sv -----
// ----------------------------------------------------------------------------
// ffhp_checker
// Port-level checks of the header frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ff_header_frame_parser_unit_defines.svh"

module ffhp_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       rx_ready,
	input wire logic       res_valid,
	input wire logic       res_ready,
	input wire logic [7:0] frame_type,
	input wire logic [4:0] frame_length,
	input wire logic [3:0] param_index,
	input wire logic [7:0] param_value,
	input wire logic       param_present,
	input wire logic       last_item
);
	logic res_acc;

	assign res_acc = res_valid && res_ready;

	// parser never takes a word while a result is shown
	`FFHP_ASSERT_SAME(a_no_overlap, clk, arst_n, res_valid, !rx_ready, "ready while result shown")

	// stalled result word holds
	`FFHP_ASSERT_NEXT(a_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable({frame_type, frame_length, param_index, param_value, param_present, last_item}), "stalled result changed")

	// zero-length result is a lone, empty, final word
	`FFHP_ASSERT_SAME(a_empty, clk, arst_n, res_valid && !param_present, last_item && (param_index == 4'd0) && (param_value == 8'd0) && (frame_length == 5'd0), "bad empty result")

	// after the final word the parser is back to taking input
	`FFHP_ASSERT_NEXT(a_end, clk, arst_n, res_acc && last_item, !res_valid && rx_ready, "no return after last")

	// more words of the frame follow a non-final word
	`FFHP_ASSERT_NEXT(a_more, clk, arst_n, res_acc && !last_item, !rx_ready, "input taken mid frame")

endmodule

bind ff_header_frame_parser_unit ffhp_checker u_ffhp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rx_ready      (rx_ch.ready),
	.res_valid     (res_ch.valid),
	.res_ready     (res_ch.ready),
	.frame_type    (res_ch.frame_type),
	.frame_length  (res_ch.frame_length),
	.param_index   (res_ch.param_index),
	.param_value   (res_ch.param_value),
	.param_present (res_ch.param_present),
	.last_item     (res_ch.last_item)
);

`default_nettype wire
